// ===== design/dual_chip_lcd_pixel_plotter_core_defines.svh =====
// Assertion macros used by the checker module.
`ifndef DUAL_CHIP_LCD_PIXEL_PLOTTER_CORE_DEFINES_SVH
`define DUAL_CHIP_LCD_PIXEL_PLOTTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DCLPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dclpp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DCLPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dclpp assertion failed");

`endif

// ===== design/dclpp_pkg.sv =====
`default_nettype none

package dclpp_pkg;

    // Result kinds
    localparam logic [2:0] K_WCMD   = 3'd0;
    localparam logic [2:0] K_WDATA  = 3'd1;
    localparam logic [2:0] K_RDATA  = 3'd2;
    localparam logic [2:0] K_RSTAT  = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;
    localparam logic [2:0] K_REJECT = 3'd5;

    // Display controller commands and limits
    localparam logic [7:0] CMD_SET_COLUMN = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
    localparam int unsigned STATUS_BUSY_BIT = 7;
    localparam logic [7:0] MAX_X      = 8'd128;
    localparam logic [7:0] MAX_Y      = 8'd64;
    localparam logic [7:0] RIGHT_BASE = 8'd65;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // One queued job for the output side: a first result and, if pair is
    // set, a trailing status read on the same chip.
    typedef struct packed {
        logic [2:0] kind;
        logic       chip;
        logic [7:0] bus_byte;
        logic       pair;
    } t_desc;

endpackage

`default_nettype wire

// ===== design/dclpp_front.sv =====
`default_nettype none

module dclpp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_op,
    input  wire logic [7:0]      i_x,
    input  wire logic [7:0]      i_y,
    input  wire logic            i_set_pixel,
    input  wire logic [7:0]      i_read_byte,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output dclpp_pkg::t_desc     o_desc
);
    import dclpp_pkg::*;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_COL_ST     = 4'd1;
    localparam logic [3:0] PH_PAGE_ST    = 4'd2;
    localparam logic [3:0] PH_DUMMY_DATA = 4'd3;
    localparam logic [3:0] PH_DUMMY_ST   = 4'd4;
    localparam logic [3:0] PH_REAL_DATA  = 4'd5;
    localparam logic [3:0] PH_REAL_ST    = 4'd6;
    localparam logic [3:0] PH_COL2_ST    = 4'd7;
    localparam logic [3:0] PH_DATA_ST    = 4'd8;

    logic [3:0] r_phase, n_phase;
    logic       r_chip, n_chip;
    logic [5:0] r_column, n_column;
    logic [2:0] r_page, n_page;
    logic [7:0] r_mask, n_mask;
    logic       r_set, n_set;
    logic [7:0] r_fetched, n_fetched;

    logic       accept;
    logic       in_range;
    logic       is_right;
    logic [7:0] x_off;
    logic [7:0] y_m1;
    logic [7:0] wr_byte;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign in_range = (i_x != 8'd0) && (i_y != 8'd0) && (i_x <= MAX_X) && (i_y <= MAX_Y);
    assign is_right = (i_x >= RIGHT_BASE);
    assign x_off    = is_right ? (i_x - RIGHT_BASE) : (i_x - 8'd1);
    assign y_m1     = i_y - 8'd1;
    assign wr_byte  = r_set ? (r_fetched | r_mask) : (r_fetched & ~r_mask);

    always_comb begin
        n_phase   = r_phase;
        n_chip    = r_chip;
        n_column  = r_column;
        n_page    = r_page;
        n_mask    = r_mask;
        n_set     = r_set;
        n_fetched = r_fetched;
        o_push    = 1'b0;
        o_desc    = '{kind: K_RSTAT, chip: r_chip, bus_byte: 8'd0, pair: 1'b0};

        if (accept) begin
            if (!i_op) begin
                o_push = 1'b1;
                if ((r_phase != PH_IDLE) || !in_range) begin
                    o_desc = '{kind: K_REJECT, chip: 1'b0, bus_byte: 8'd0, pair: 1'b0};
                end else begin
                    n_chip   = is_right;
                    n_column = x_off[5:0];
                    n_page   = y_m1[5:3];
                    n_mask   = 8'd1 << y_m1[2:0];
                    n_set    = i_set_pixel;
                    n_phase  = PH_COL_ST;
                    o_desc   = '{kind: K_WCMD, chip: is_right,
                                 bus_byte: CMD_SET_COLUMN | {2'b00, x_off[5:0]}, pair: 1'b1};
                end
            end else if (r_phase != PH_IDLE) begin
                o_push = 1'b1;
                if ((r_phase == PH_DUMMY_DATA) || (r_phase == PH_REAL_DATA)) begin
                    // data byte answered; poll status next
                    if (r_phase == PH_REAL_DATA) begin
                        n_fetched = i_read_byte;
                        n_phase   = PH_REAL_ST;
                    end else begin
                        n_phase = PH_DUMMY_ST;
                    end
                end else if (i_read_byte[STATUS_BUSY_BIT]) begin
                    // still busy: poll again, default descriptor
                end else begin
                    unique case (r_phase)
                        PH_COL_ST: begin
                            n_phase = PH_PAGE_ST;
                            o_desc  = '{kind: K_WCMD, chip: r_chip,
                                        bus_byte: CMD_SET_PAGE | {5'd0, r_page}, pair: 1'b1};
                        end
                        PH_PAGE_ST: begin
                            n_phase = PH_DUMMY_DATA;
                            o_desc.kind = K_RDATA;
                        end
                        PH_DUMMY_ST: begin
                            n_phase = PH_REAL_DATA;
                            o_desc.kind = K_RDATA;
                        end
                        PH_REAL_ST: begin
                            n_phase = PH_COL2_ST;
                            o_desc  = '{kind: K_WCMD, chip: r_chip,
                                        bus_byte: CMD_SET_COLUMN | {2'b00, r_column}, pair: 1'b1};
                        end
                        PH_COL2_ST: begin
                            n_phase = PH_DATA_ST;
                            o_desc  = '{kind: K_WDATA, chip: r_chip,
                                        bus_byte: wr_byte, pair: 1'b1};
                        end
                        PH_DATA_ST: begin
                            n_phase = PH_IDLE;
                            o_desc.kind = K_DONE;
                        end
                        default: begin
                            // unused codes: drop back to idle, no result
                            n_phase = PH_IDLE;
                            o_push  = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chip    <= n_chip;
        r_column  <= n_column;
        r_page    <= n_page;
        r_mask    <= n_mask;
        r_set     <= n_set;
        r_fetched <= n_fetched;
    end

endmodule

`default_nettype wire

// ===== design/dclpp_queue.sv =====
`default_nettype none

module dclpp_queue #(
    parameter int unsigned DEPTH = dclpp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dclpp_pkg::t_desc  i_wdata,
    output logic                   o_full,
    input  wire logic              i_pop,
    output dclpp_pkg::t_desc       o_rdata,
    output logic                   o_empty
);
    import dclpp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/dclpp_back.sv =====
`default_nettype none

module dclpp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire dclpp_pkg::t_desc  i_desc,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_kind,
    output logic                   o_chip,
    output logic [7:0]             o_bus_byte,
    output logic                   o_last
);
    import dclpp_pkg::*;

    logic       r_valid, n_valid;
    logic       r_pend, n_pend;
    logic [2:0] r_kind, n_kind;
    logic       r_chip, n_chip;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && !i_q_empty;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_kind  = r_kind;
        n_chip  = r_chip;
        n_byte  = r_byte;
        n_last  = r_last;
        if (load) begin
            if (r_pend) begin
                // trailing status read, same chip
                n_valid = 1'b1;
                n_pend  = 1'b0;
                n_kind  = K_RSTAT;
                n_byte  = 8'd0;
                n_last  = 1'b1;
            end else begin
                n_valid = !i_q_empty;
                n_pend  = !i_q_empty && i_desc.pair;
                n_kind  = i_desc.kind;
                n_chip  = i_desc.chip;
                n_byte  = i_desc.bus_byte;
                n_last  = !i_desc.pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_chip <= n_chip;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_chip     = r_chip;
    assign o_bus_byte = r_byte;
    assign o_last     = r_last;

endmodule

`default_nettype wire

// ===== design/dual_chip_lcd_pixel_plotter_core.sv =====
// Pixel plotter for a 128x64 display made of two 64-column controller chips.
// A plot request (tuser = 0) carries a 1-based column x (1..128), row y
// (1..64) and a set flag; out-of-range x or y, or a request while a plot is
// still running, is answered by a single "rejected" result. An accepted
// request drives the bus sequence set column, set page, dummy read, real read,
// set column again, and write of the read byte with the pixel bit set or
// cleared. Every transaction is followed by a status read; feed each byte the
// display returns back in as a response item (tuser = 1), and the plotter
// polls again while status bit 7 is high. Responses that arrive with no plot
// running are dropped without a result. Every other item yields one or two
// results (transaction plus its status read), the last marked by tlast;
// "plot done" closes a sequence. The input side takes one item per cycle as
// long as the job queue (QUEUE_DEPTH entries) has room; the output register
// emits one result per cycle while m_axis_tready is high, so sustained input
// rate is bounded by the output side: items that cause two results hold it
// while both go out. An accepted item is written into the job queue, and the
// back end then loads its first result into the output register.

`default_nettype none

module dual_chip_lcd_pixel_plotter_core #(
    parameter int unsigned QUEUE_DEPTH = dclpp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request / response stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // x[7:0], y[15:8], set_pixel[16], read_byte[24:17]
    input  wire logic        s_axis_tuser,  // op: 0 plot request, 1 read response
    // bus transaction / status stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // chip[0], bus_byte[8:1]
    output logic [2:0]       m_axis_tuser,  // kind[2:0]
    output logic             m_axis_tlast
);
    import dclpp_pkg::*;

    t_desc      front_desc;
    t_desc      queue_desc;
    logic       front_push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       out_chip;
    logic [7:0] out_byte;

    // Front: classify items and step the plot sequencer.
    dclpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_x         (s_axis_tdata[7:0]),
        .i_y         (s_axis_tdata[15:8]),
        .i_set_pixel (s_axis_tdata[16]),
        .i_read_byte (s_axis_tdata[24:17]),
        .i_q_full    (q_full),
        .o_push      (front_push),
        .o_desc      (front_desc)
    );

    // Job queue decouples sequencer from output stalls.
    dclpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (queue_desc),
        .o_empty (q_empty)
    );

    // Back: expand each job into its one or two results.
    dclpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_desc     (queue_desc),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_kind     (m_axis_tuser),
        .o_chip     (out_chip),
        .o_bus_byte (out_byte),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_byte, out_chip};

endmodule

`default_nettype wire

// ===== design/dclpp_checker.sv =====
`default_nettype none

`include "dual_chip_lcd_pixel_plotter_core_defines.svh"

module dclpp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import dclpp_pkg::*;

    // A stalled result holds.
    `DCLPP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // A transaction that is not last is followed at once by its status read.
    `DCLPP_ASSERT_NEXT(a_pair, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && (m_axis_tuser == K_RSTAT) && (m_axis_tdata[0] == $past(m_axis_tdata[0])))

    // Done and reject stand alone.
    `DCLPP_ASSERT_NOW(a_single, i_clk, i_rst_n, m_axis_tvalid && ((m_axis_tuser == K_DONE) || (m_axis_tuser == K_REJECT)), m_axis_tlast)

    // Only writes carry a byte; rejects address chip 0.
    `DCLPP_ASSERT_NOW(a_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != K_WCMD) && (m_axis_tuser != K_WDATA), (m_axis_tdata[8:1] == 8'd0) && ((m_axis_tuser != K_REJECT) || !m_axis_tdata[0]))

endmodule

bind dual_chip_lcd_pixel_plotter_core dclpp_checker u_checker (.*);

`default_nettype wire
